// ===== design/wrs_pkg.sv =====
// Package: shared constants, codes and the result record for the WAV stream parser.
`timescale 1ns / 1ps
package wrs_pkg;

  localparam int unsigned LenW   = 32;
  localparam int unsigned AlignW = 16;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FMT    = 2'd1;
  localparam logic [1:0] KIND_ERR    = 2'd2;

  localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ERR_NO_FMT      = 3'd2;
  localparam logic [2:0] ERR_PCM_DEPTH   = 3'd3;
  localparam logic [2:0] ERR_FLT_DEPTH   = 3'd4;
  localparam logic [2:0] ERR_BAD_FORMAT  = 3'd5;
  localparam logic [2:0] ERR_MISSING     = 3'd6;
  localparam logic [2:0] ERR_ZERO_ALIGN  = 3'd7;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_word;
    logic        is_float;
    logic [15:0] channel_index;
    logic        last_sample;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bits_per_sample;
    logic [31:0] frame_count;
    logic [2:0]  error_code;
  } res_t;

endpackage

// ===== design/wrs_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wrs_div #(
  parameter int unsigned NW = wrs_pkg::LenW,
  parameter int unsigned DW = wrs_pkg::AlignW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted  = {rem[DW-1:0], quo[NW-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign busy     = cnt != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? shifted - {1'b0, dvs} : shifted;
      quo <= {quo[NW-2:0], fits};
    end
  end
endmodule

// ===== design/wav_riff_stream_parser_top.sv =====
// Top level: WAV/RIFF byte stream parser with format info and sample output.
`timescale 1ns / 1ps
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_stall, data_byte, last_byte  | one file byte per request
//  out     | out_valid, out_stall, kind .. error_code  | sample, format info, error
//
// One byte per cycle through the header, chunk walk and sample data while in_stall is low.
// At the data chunk header the frame count (data length / block align) comes from
// the restoring divider (32 steps, then its done strobe) plus a multiply step,
// so in_stall holds through PH_DIV and PH_MUL and the format info is loaded in PH_MUL.
// Reset (rst, synchronous) returns to "expect RIFF tag"; last_byte does the same.
// in_stall is high while dividing and multiplying and while a result is held by out_stall.
module wav_riff_stream_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] sample_word,
  output logic        is_float,
  output logic [15:0] channel_index,
  output logic        last_sample,
  output logic [31:0] sample_rate,
  output logic [15:0] channel_count,
  output logic [15:0] bits_per_sample,
  output logic [31:0] frame_count,
  output logic [2:0]  error_code
);
  localparam logic [3:0] PH_RIFF = 4'd0;
  localparam logic [3:0] PH_SIZE = 4'd1;
  localparam logic [3:0] PH_WAVE = 4'd2;
  localparam logic [3:0] PH_ID   = 4'd3;
  localparam logic [3:0] PH_LEN  = 4'd4;
  localparam logic [3:0] PH_FMT  = 4'd5;
  localparam logic [3:0] PH_SKIP = 4'd6;
  localparam logic [3:0] PH_DATA = 4'd7;
  localparam logic [3:0] PH_HALT = 4'd8;
  localparam logic [3:0] PH_DIV  = 4'd9;
  localparam logic [3:0] PH_MUL  = 4'd10;

  // parser state
  logic [3:0]  phase, phase_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] tag, tag_next;
  logic [31:0] clen, clen_next;
  logic [15:0] fcode, fcode_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] balign, balign_next;
  logic [15:0] depth, depth_next;
  logic        fmt_seen, fmt_seen_next;
  logic [31:0] asm_word, asm_word_next;
  logic [47:0] left, left_next;
  logic [15:0] chidx, chidx_next;
  logic [31:0] frames, frames_next;
  logic        pend_last, pend_last_next;

  // result register
  wrs_pkg::res_t res, res_n;
  logic          res_load;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [31:0]       div_quo;

  logic        acc;
  logic        do_clear;
  logic [3:0]  cnt_inc;
  logic [31:0] tag_sh;
  logic [31:0] asm_sh;
  logic [2:0]  nbytes;
  logic [47:0] left_dec;
  logic [15:0] ch_inc;
  logic [47:0] product;

  assign in_stall = (phase == PH_DIV) || (phase == PH_MUL) || (out_valid && out_stall);
  assign acc      = in_valid && !in_stall;
  assign cnt_inc  = cnt + 4'd1;
  assign tag_sh   = {data_byte, tag[31:8]};
  assign asm_sh   = {data_byte, asm_word[31:8]};
  assign nbytes   = depth[5:3];
  assign left_dec = left - 48'd1;
  assign ch_inc   = chidx + 16'd1;
  assign product  = {16'd0, frames} * {32'd0, chans};

  wrs_div #(
    .NW(wrs_pkg::LenW),
    .DW(wrs_pkg::AlignW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(tag_sh),
    .divisor (balign),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    tag_next       = tag;
    clen_next      = clen;
    fcode_next     = fcode;
    chans_next     = chans;
    rate_next      = rate;
    balign_next    = balign;
    depth_next     = depth;
    fmt_seen_next  = fmt_seen;
    asm_word_next  = asm_word;
    left_next      = left;
    chidx_next     = chidx;
    frames_next    = frames;
    pend_last_next = pend_last;
    res_load       = 1'b0;
    res_n          = '0;
    div_start      = 1'b0;
    do_clear       = 1'b0;

    if (phase == PH_DIV) begin
      if (div_done) begin
        frames_next = div_quo;
        phase_next  = PH_MUL;
      end
    end else if (phase == PH_MUL) begin
      left_next             = product;
      res_load              = 1'b1;
      res_n.kind            = wrs_pkg::KIND_FMT;
      res_n.is_float        = fcode == wrs_pkg::FMT_FLOAT;
      res_n.sample_rate     = rate;
      res_n.channel_count   = chans;
      res_n.bits_per_sample = depth;
      res_n.frame_count     = frames;
      cnt_next              = '0;
      asm_word_next         = '0;
      chidx_next            = '0;
      phase_next            = (product == '0) ? PH_HALT : PH_DATA;
      do_clear              = pend_last;
    end else if (acc) begin
      unique case (phase) inside
        PH_RIFF, PH_SIZE, PH_WAVE, PH_ID, PH_LEN: begin
          tag_next = tag_sh;
          cnt_next = cnt_inc;
          if (cnt == 4'd3) begin
            cnt_next = '0;
            unique case (phase)
              PH_RIFF: begin
                if (tag_sh != wrs_pkg::TAG_RIFF) begin
                  res_load = 1'b1; res_n.kind = wrs_pkg::KIND_ERR;
                  res_n.error_code = wrs_pkg::ERR_NOT_RIFF; phase_next = PH_HALT;
                end else phase_next = PH_SIZE;
              end
              PH_SIZE: phase_next = PH_WAVE;
              PH_WAVE: begin
                if (tag_sh != wrs_pkg::TAG_WAVE) begin
                  res_load = 1'b1; res_n.kind = wrs_pkg::KIND_ERR;
                  res_n.error_code = wrs_pkg::ERR_NOT_WAVE; phase_next = PH_HALT;
                end else phase_next = PH_ID;
              end
              PH_ID: begin
                // chunk id parks in clen until its length is in
                clen_next  = tag_sh;
                phase_next = PH_LEN;
              end
              default: begin
                clen_next = tag_sh;
                if (clen == wrs_pkg::TAG_FMT) begin
                  phase_next = PH_FMT;
                end else if (clen == wrs_pkg::TAG_DATA) begin
                  // data header checks: missing fmt, zero align, then format/depth
                  res_n.kind = wrs_pkg::KIND_ERR;
                  if (!fmt_seen) begin
                    res_load = 1'b1; res_n.error_code = wrs_pkg::ERR_NO_FMT;
                  end else if (balign == '0) begin
                    res_load = 1'b1; res_n.error_code = wrs_pkg::ERR_ZERO_ALIGN;
                  end else if (fcode == wrs_pkg::FMT_PCM) begin
                    if (depth != 16'd16 && depth != 16'd24 && depth != 16'd32) begin
                      res_load = 1'b1; res_n.error_code = wrs_pkg::ERR_PCM_DEPTH;
                    end
                  end else if (fcode == wrs_pkg::FMT_FLOAT) begin
                    if (depth != 16'd32) begin
                      res_load = 1'b1; res_n.error_code = wrs_pkg::ERR_FLT_DEPTH;
                    end
                  end else begin
                    res_load = 1'b1; res_n.error_code = wrs_pkg::ERR_BAD_FORMAT;
                  end
                  if (res_load) begin
                    phase_next = PH_HALT;
                  end else begin
                    res_n          = '0;
                    div_start      = 1'b1;
                    phase_next     = PH_DIV;
                    pend_last_next = last_byte;
                  end
                end else begin
                  phase_next = (tag_sh == '0) ? PH_ID : PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_FMT: begin
          case (cnt) inside
            4'd0: begin
              fcode_next  = {8'd0, data_byte};
              chans_next  = '0;
              rate_next   = '0;
              balign_next = '0;
              depth_next  = '0;
            end
            4'd1:               fcode_next[15:8] = data_byte;
            4'd2, 4'd3:         chans_next[{cnt[0], 3'b000} +: 8] = data_byte;
            [4'd4:4'd7]:        rate_next[{cnt[1:0], 3'b000} +: 8] = data_byte;
            4'd12, 4'd13:       balign_next[{cnt[0], 3'b000} +: 8] = data_byte;
            4'd14, 4'd15:       depth_next[{cnt[0], 3'b000} +: 8] = data_byte;
            default: ;          // byte rate is not kept
          endcase
          cnt_next = cnt_inc;
          if (cnt == 4'd15) begin
            fmt_seen_next = 1'b1;
            clen_next     = (clen > 32'd16) ? clen - 32'd16 : '0;
            phase_next    = (clen > 32'd16) ? PH_SKIP : PH_ID;
          end
        end
        PH_SKIP: begin
          clen_next = clen - 32'd1;
          if (clen == 32'd1) phase_next = PH_ID;
        end
        PH_DATA: begin
          asm_word_next = asm_sh;
          cnt_next      = cnt_inc;
          if (cnt_inc >= {1'b0, nbytes}) begin
            cnt_next             = '0;
            asm_word_next        = '0;
            res_load             = 1'b1;
            res_n.kind           = wrs_pkg::KIND_SAMPLE;
            res_n.sample_word    = (nbytes == 3'd3) ? {asm_sh[31:8], 8'd0} : asm_sh;
            res_n.is_float       = fcode == wrs_pkg::FMT_FLOAT;
            res_n.channel_index  = chidx;
            res_n.last_sample    = left_dec == '0;
            left_next            = left_dec;
            chidx_next           = (ch_inc >= chans) ? '0 : ch_inc;
            if (left_dec == '0) phase_next = PH_HALT;
          end
        end
        default: ;
      endcase

      // end of file: truncation errors, then back to reset state (after the format info if a divide starts)
      if (last_byte) begin
        if (!res_load) begin
          if (phase_next == PH_RIFF) begin
            res_load = 1'b1; res_n.kind = wrs_pkg::KIND_ERR;
            res_n.error_code = wrs_pkg::ERR_NOT_RIFF;
          end else if (phase_next == PH_SIZE || phase_next == PH_WAVE) begin
            res_load = 1'b1; res_n.kind = wrs_pkg::KIND_ERR;
            res_n.error_code = wrs_pkg::ERR_NOT_WAVE;
          end else if (phase_next == PH_ID || phase_next == PH_LEN ||
                       phase_next == PH_FMT || phase_next == PH_SKIP) begin
            res_load = 1'b1; res_n.kind = wrs_pkg::KIND_ERR;
            res_n.error_code = wrs_pkg::ERR_MISSING;
          end
        end
        if (phase_next != PH_DIV) do_clear = 1'b1;
      end
    end

    if (do_clear) begin
      phase_next     = PH_RIFF;
      cnt_next       = '0;
      tag_next       = '0;
      clen_next      = '0;
      fcode_next     = '0;
      chans_next     = '0;
      rate_next      = '0;
      balign_next    = '0;
      depth_next     = '0;
      fmt_seen_next  = 1'b0;
      asm_word_next  = '0;
      left_next      = '0;
      chidx_next     = '0;
      pend_last_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RIFF;
      cnt       <= '0;
      tag       <= '0;
      clen      <= '0;
      fcode     <= '0;
      chans     <= '0;
      rate      <= '0;
      balign    <= '0;
      depth     <= '0;
      fmt_seen  <= 1'b0;
      asm_word  <= '0;
      left      <= '0;
      chidx     <= '0;
      frames    <= '0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      tag       <= tag_next;
      clen      <= clen_next;
      fcode     <= fcode_next;
      chans     <= chans_next;
      rate      <= rate_next;
      balign    <= balign_next;
      depth     <= depth_next;
      fmt_seen  <= fmt_seen_next;
      asm_word  <= asm_word_next;
      left      <= left_next;
      chidx     <= chidx_next;
      frames    <= frames_next;
      pend_last <= pend_last_next;
      out_valid <= res_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= res_n;
  end

  assign kind            = res.kind;
  assign sample_word     = res.sample_word;
  assign is_float        = res.is_float;
  assign channel_index   = res.channel_index;
  assign last_sample     = res.last_sample;
  assign sample_rate     = res.sample_rate;
  assign channel_count   = res.channel_count;
  assign bits_per_sample = res.bits_per_sample;
  assign frame_count     = res.frame_count;
  assign error_code      = res.error_code;

`ifndef SYNTH
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> phase == PH_DIV)
    else $error("divider busy outside divide phase");

  a_mul_emits_fmt: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MUL |=> out_valid && kind == wrs_pkg::KIND_FMT)
    else $error("format info not issued after frame count");

  a_no_load_when_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !res_load)
    else $error("result overwritten while held");
`endif
endmodule

// ===== tb/tb_wav_riff_stream_parser_top.sv =====
// Testbench for the WAV/RIFF stream parser: scripted and random files, scoreboard check.
`timescale 1ns / 1ps
module tb_wav_riff_stream_parser_top;

  // Bit-accurate prediction of the parser plus the queue of expected results.
  class wav_scoreboard;
    typedef enum logic [3:0] {
      PH_RIFF, PH_SIZE, PH_WAVE, PH_ID, PH_LEN, PH_FMT, PH_SKIP, PH_DATA, PH_HALT
    } phase_e;

    phase_e      phase;
    logic [31:0] cnt, shreg, clen, rate;
    logic [15:0] fcode, chans, balign, depth, chan_ctr;
    logic        have_fmt;
    logic [31:0] asm_word;
    logic [47:0] remaining;
    wrs_pkg::res_t pending[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_RIFF; cnt = 0; shreg = 0; clen = 0; rate = 0;
      fcode = 0; chans = 0; balign = 0; depth = 0; chan_ctr = 0;
      have_fmt = 0; asm_word = 0; remaining = 0;
    endfunction

    function wrs_pkg::res_t fail(logic [2:0] code);
      wrs_pkg::res_t r;
      r = '0;
      r.kind = wrs_pkg::KIND_ERR;
      r.error_code = code;
      phase = PH_HALT;
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic last);
      wrs_pkg::res_t r;
      bit   got;
      logic [31:0] id, frames, nb;
      got = 0;
      r = '0;
      case (phase)
        PH_RIFF, PH_SIZE, PH_WAVE, PH_ID, PH_LEN: begin
          shreg = {b, shreg[31:8]};
          cnt++;
          if (cnt == 4) begin
            cnt = 0;
            case (phase)
              PH_RIFF: if (shreg != wrs_pkg::TAG_RIFF) begin
                         r = fail(wrs_pkg::ERR_NOT_RIFF); got = 1;
                       end else phase = PH_SIZE;
              PH_SIZE: phase = PH_WAVE;
              PH_WAVE: if (shreg != wrs_pkg::TAG_WAVE) begin
                         r = fail(wrs_pkg::ERR_NOT_WAVE); got = 1;
                       end else phase = PH_ID;
              PH_ID: begin clen = shreg; phase = PH_LEN; end
              default: begin
                id = clen;
                clen = shreg;
                if (id == wrs_pkg::TAG_FMT) phase = PH_FMT;
                else if (id == wrs_pkg::TAG_DATA) begin
                  got = 1;
                  // check order: missing fmt, zero align, then format and depth
                  if (!have_fmt) r = fail(wrs_pkg::ERR_NO_FMT);
                  else if (balign == 0) r = fail(wrs_pkg::ERR_ZERO_ALIGN);
                  else if (fcode == wrs_pkg::FMT_PCM &&
                           !(depth == 16 || depth == 24 || depth == 32))
                    r = fail(wrs_pkg::ERR_PCM_DEPTH);
                  else if (fcode == wrs_pkg::FMT_FLOAT && depth != 32)
                    r = fail(wrs_pkg::ERR_FLT_DEPTH);
                  else if (fcode != wrs_pkg::FMT_PCM && fcode != wrs_pkg::FMT_FLOAT)
                    r = fail(wrs_pkg::ERR_BAD_FORMAT);
                  else begin
                    frames = clen / {16'd0, balign};
                    r.kind = wrs_pkg::KIND_FMT;
                    r.is_float = (fcode == wrs_pkg::FMT_FLOAT);
                    r.sample_rate = rate;
                    r.channel_count = chans;
                    r.bits_per_sample = depth;
                    r.frame_count = frames;
                    remaining = 48'(frames) * 48'(chans);
                    chan_ctr = 0; cnt = 0; asm_word = 0;
                    phase = (remaining == 0) ? PH_HALT : PH_DATA;
                  end
                end else phase = (clen == 0) ? PH_ID : PH_SKIP;
              end
            endcase
          end
        end
        PH_FMT: begin
          if (cnt == 0) begin fcode = 0; chans = 0; rate = 0; balign = 0; depth = 0; end
          case (cnt)
            0: fcode[7:0] = b;   1: fcode[15:8] = b;
            2: chans[7:0] = b;   3: chans[15:8] = b;
            4: rate[7:0] = b;    5: rate[15:8] = b;
            6: rate[23:16] = b;  7: rate[31:24] = b;
            12: balign[7:0] = b; 13: balign[15:8] = b;
            14: depth[7:0] = b;  15: depth[15:8] = b;
            default: ;
          endcase
          cnt++;
          if (cnt == 16) begin
            cnt = 0;
            have_fmt = 1;
            clen = (clen > 16) ? clen - 16 : 0;
            phase = (clen == 0) ? PH_ID : PH_SKIP;
          end
        end
        PH_SKIP: begin
          clen--;
          if (clen == 0) phase = PH_ID;
        end
        PH_DATA: begin
          nb = {16'd0, depth} >> 3;
          asm_word = {b, asm_word[31:8]};
          cnt++;
          if (cnt >= nb) begin
            cnt = 0;
            r.kind = wrs_pkg::KIND_SAMPLE;
            r.sample_word = (nb == 3) ? {asm_word[31:8], 8'd0} : asm_word;
            r.is_float = (fcode == wrs_pkg::FMT_FLOAT);
            r.channel_index = chan_ctr;
            remaining--;
            r.last_sample = (remaining == 0);
            chan_ctr++;
            if (chan_ctr >= chans) chan_ctr = 0;
            asm_word = 0;
            if (remaining == 0) phase = PH_HALT;
            got = 1;
          end
        end
        default: ;
      endcase
      if (last) begin
        // truncated file reports which header stage it died in
        if (!got) begin
          if (phase == PH_RIFF) begin
            r = fail(wrs_pkg::ERR_NOT_RIFF); got = 1;
          end else if (phase == PH_SIZE || phase == PH_WAVE) begin
            r = fail(wrs_pkg::ERR_NOT_WAVE); got = 1;
          end else if (phase <= PH_SKIP) begin
            r = fail(wrs_pkg::ERR_MISSING); got = 1;
          end
        end
        clear();
      end
      if (got) pending.push_back(r);
    endfunction

    function void check_result(wrs_pkg::res_t act);
      wrs_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
        return;
      end
      exp_r = pending.pop_front();
      if (act !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h actual %h", exp_r, act);
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall, last_byte = 0, out_valid, out_stall = 0;
  logic [7:0]  data_byte = 0;
  logic [1:0]  kind;
  logic [31:0] sample_word, sample_rate, frame_count;
  logic        is_float, last_sample;
  logic [15:0] channel_index, channel_count, bits_per_sample;
  logic [2:0]  error_code;

  wav_riff_stream_parser_top u_dut (.*);

  always #6 clk = ~clk;

  wav_scoreboard sb = new();
  typedef struct { logic [7:0] b; logic l; } wbyte_t;
  wbyte_t stream[$];
  int  idle_cycles = 0;
  int  sent_cnt = 0;
  bit  stim_done = 0, hold_off = 0;

  // --- file builders ---------------------------------------------------------
  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) stream.push_back('{v[8*i +: 8], 1'b0});
  endtask

  task automatic put16(logic [15:0] v);
    stream.push_back('{v[7:0], 1'b0});
    stream.push_back('{v[15:8], 1'b0});
  endtask

  task automatic end_file();
    if (stream.size() == 0) stream.push_back('{8'h00, 1'b1});
    else stream[$].l = 1'b1;
  endtask

  // Well-formed-ish file; fields passed in so directed cases can bend them.
  task automatic make_wav(logic [15:0] fc, logic [15:0] ch, logic [31:0] rt,
                          logic [15:0] ba, logic [15:0] dp, logic [31:0] fmt_len,
                          int nframes_bytes, bit junk_chunk, int trail);
    int extra;
    put32(wrs_pkg::TAG_RIFF); put32($urandom); put32(wrs_pkg::TAG_WAVE);
    if (junk_chunk) begin
      extra = $urandom_range(0, 5);
      put32(32'h4B4E_554A); put32(extra);
      for (int i = 0; i < extra; i++) stream.push_back('{8'($urandom), 1'b0});
    end
    put32(wrs_pkg::TAG_FMT); put32(fmt_len);
    put16(fc); put16(ch); put32(rt); put32($urandom); put16(ba); put16(dp);
    for (int i = 16; i < fmt_len; i++) stream.push_back('{8'($urandom), 1'b0});
    put32(wrs_pkg::TAG_DATA); put32(nframes_bytes);
    for (int i = 0; i < nframes_bytes + trail; i++)
      stream.push_back('{8'($urandom), 1'b0});
    end_file();
  endtask

  task automatic random_file();
    int sel, dp, ch, nfr;
    logic [15:0] fc;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      case ($urandom_range(0, 3))
        0: begin fc = wrs_pkg::FMT_PCM; dp = 16; end
        1: begin fc = wrs_pkg::FMT_PCM; dp = 24; end
        2: begin fc = wrs_pkg::FMT_PCM; dp = 32; end
        default: begin fc = wrs_pkg::FMT_FLOAT; dp = 32; end
      endcase
      ch = $urandom_range(1, 3);
      nfr = $urandom_range(0, 6);
      make_wav(fc, 16'(ch), $urandom, 16'(ch * dp / 8), 16'(dp),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16,
               nfr * ch * dp / 8 + $urandom_range(0, 1), $urandom_range(0, 1),
               $urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) begin
        // cut the file short somewhere
        sel = $urandom_range(1, stream.size() - 1);
        while (stream.size() > sel) void'(stream.pop_back());
        end_file();
      end
    end else if (sel == 7) begin
      make_wav(16'($urandom_range(0, 4)), 16'($urandom), $urandom,
               16'($urandom_range(0, 2)), 16'($urandom_range(0, 40)), 16,
               $urandom_range(0, 4), 0, 0);
    end else begin
      for (int i = 0; i < $urandom_range(1, 20); i++)
        stream.push_back('{8'($urandom), 1'($urandom_range(0, 15) == 0)});
      end_file();
    end
  endtask

  // --- sender: bursts with gaps ----------------------------------------------
  task automatic send_stream();
    wbyte_t w;
    int burst;
    while (stream.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && stream.size() > 0) begin
        w = stream.pop_front();
        @(negedge clk);
        in_valid <= 1; data_byte <= w.b; last_byte <= w.l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(w.b, w.l);
        sent_cnt++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        in_valid <= 0; data_byte <= 8'($urandom); last_byte <= 1'($urandom);
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 0;
  endtask

  // --- receiver stall pattern, with one long hold-off -----------------------
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1;
      else begin
        mode = $urandom_range(0, 99);
        out_stall <= (mode < 30);
      end
    end
  end

  initial begin
    @(negedge rst);
    repeat (600) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  // --- result monitor and watchdog ------------------------------------------
  always @(posedge clk) begin
    wrs_pkg::res_t r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        r.kind = kind; r.sample_word = sample_word; r.is_float = is_float;
        r.channel_index = channel_index; r.last_sample = last_sample;
        r.sample_rate = sample_rate; r.channel_count = channel_count;
        r.bits_per_sample = bits_per_sample; r.frame_count = frame_count;
        r.error_code = error_code;
        sb.check_result(r);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --- main sequence ---------------------------------------------------------
  initial begin
    int wait_cnt;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed files
    make_wav(wrs_pkg::FMT_PCM, 1, 32'hFFFF_FFFF, 2, 16, 16, 4, 0, 0);
    make_wav(wrs_pkg::FMT_PCM, 2, 0, 6, 24, 18, 12, 1, 2);
    make_wav(wrs_pkg::FMT_PCM, 1, 44100, 4, 32, 8, 8, 0, 0);           // short fmt chunk
    make_wav(wrs_pkg::FMT_FLOAT, 1, 48000, 4, 32, 16, 8, 0, 1);
    make_wav(wrs_pkg::FMT_PCM, 0, 8000, 2, 16, 16, 4, 0, 0);           // zero samples
    make_wav(wrs_pkg::FMT_PCM, 1, 8000, 0, 16, 16, 4, 0, 0);           // zero align
    make_wav(wrs_pkg::FMT_PCM, 1, 8000, 2, 8, 16, 2, 0, 0);
    make_wav(wrs_pkg::FMT_FLOAT, 1, 8000, 2, 16, 16, 2, 0, 0);
    make_wav(16'hFFFF, 16'hFFFF, 8000, 16'hFFFF, 16'hFFFF, 16, 2, 0, 0);
    put32(32'h5846_4952); end_file();                                 // not RIFF
    put32(wrs_pkg::TAG_RIFF); put32(0); put32(32'h0); end_file();     // not WAVE
    put32(wrs_pkg::TAG_RIFF); put32(0); put32(wrs_pkg::TAG_WAVE);
    put32(wrs_pkg::TAG_DATA); put32(4); end_file();
    put32(wrs_pkg::TAG_RIFF); put32(0); end_file();                   // truncated in size
    put32(wrs_pkg::TAG_RIFF); put32(0); put32(wrs_pkg::TAG_WAVE);
    put32(wrs_pkg::TAG_FMT); end_file();
    stream.push_back('{8'hFF, 1'b1});
    send_stream();
    while (sent_cnt + stream.size() < 2000) begin
      random_file();
      if (stream.size() > 200) send_stream();
    end
    send_stream();
    wait_cnt = 0;
    while (sb.pending.size() > 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== wav_riff_stream_parser_top.f =====
design/wrs_pkg.sv
design/wrs_div.sv
design/wav_riff_stream_parser_top.sv
tb/tb_wav_riff_stream_parser_top.sv
